FILE: hw/rtl/box_filter_image_downscaler_macros.svh
// Assertion macros shared by the downscaler RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef BOX_FILTER_IMAGE_DOWNSCALER_MACROS_SVH
`define BOX_FILTER_IMAGE_DOWNSCALER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define BFD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define BFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bfd_pkg.sv
// Package of the box filter downscaler: register indexes and shared types.
// Depends on nothing.
package bfd_pkg;
  localparam int NumChannels = 3;
  localparam int AddrBits    = 4;
  localparam int RowLimit    = 512;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_SCALE  = 2'd2,
    REG_MODE   = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    DIV_IDLE = 2'd0,
    DIV_RUN  = 2'd1,
    DIV_DONE = 2'd2
  } div_state_t;
endpackage

FILE: hw/rtl/bfd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module bfd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: hw/rtl/bfd_divider.sv
// Restoring divider for the three channel means, one quotient bit a cycle.
// Depends on bfd_pkg.
`include "box_filter_image_downscaler_macros.svh"
module bfd_divider import bfd_pkg::*; #(
  parameter int SumBits = 16,
  parameter int CntBits = 8,
  parameter int ChanBits = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [NumChannels-1:0][SumBits-1:0] dividend,
  input  logic [CntBits-1:0]                 divisor,
  output logic                               done,
  output logic [NumChannels-1:0][ChanBits-1:0] quotient
);
  localparam int StepBits = $clog2(SumBits + 1);

  div_state_t state, state_next;
  logic [StepBits-1:0] step;
  logic [CntBits-1:0] den;
  logic [NumChannels-1:0][SumBits-1:0] quo;
  logic [NumChannels-1:0][SumBits:0] rem;

  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE: if (start) state_next = DIV_RUN;
      DIV_RUN:  if (step == StepBits'(SumBits - 1)) state_next = DIV_DONE;
      DIV_DONE: state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    done = (state == DIV_DONE);
    for (int c = 0; c < NumChannels; c++) begin
      quotient[c] = (quo[c] > SumBits'((1 << ChanBits) - 1)) ?
                    ChanBits'((1 << ChanBits) - 1) : quo[c][ChanBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
    if (state == DIV_IDLE && start) begin
      step <= '0;
      den  <= divisor;
      for (int c = 0; c < NumChannels; c++) begin
        quo[c] <= dividend[c];
        rem[c] <= '0;
      end
    end else if (state == DIV_RUN) begin
      step <= step + 1'b1;
      for (int c = 0; c < NumChannels; c++) begin
        logic [SumBits:0] trial;
        trial = {rem[c][SumBits-1:0], quo[c][SumBits-1]};
        if (trial >= (SumBits+1)'(den)) begin
          rem[c] <= trial - (SumBits+1)'(den);
          quo[c] <= {quo[c][SumBits-2:0], 1'b1};
        end else begin
          rem[c] <= trial;
          quo[c] <= {quo[c][SumBits-2:0], 1'b0};
        end
      end
    end
  end

  `BFD_ASSERT_NEXT(a_done_after_run, clk, rst, state == DIV_DONE, state == DIV_IDLE, "divider stuck")
  `BFD_ASSERT_IMPL(a_den_nonzero, clk, rst, state == DIV_RUN, den != '0, "zero divisor")
  `BFD_ASSERT_IMPL(a_step_bound, clk, rst, state == DIV_RUN, step < StepBits'(SumBits), "step overrun")
endmodule

FILE: hw/rtl/box_filter_image_downscaler.sv
// Top level of the box filter downscaler: registers, line store, sequencer.
// Depends on bfd_pkg, bfd_ram, bfd_divider and the assertion macro header.
//
// Usage: pixels enter on the in channel (in_valid/in_stall, one beat per
// pixel, raster order). Scaled pixels leave on the out channel
// (out_valid/out_stall) with their output column, row and a frame_end flag
// on the last output pixel of the frame. Configuration goes through an
// APB-style port; registers are width, height, scale and mode at byte
// offsets 0, 4, 8 and 12, and should be written only while idle.
// Each pixel takes a line-store read stage, then an update stage that
// writes the new column sum back; no new pixel is taken until the update
// stage is done. In decimate mode a block-closing pixel's result goes to
// the output register at the end of its update stage if that is free. In
// average mode it runs the shared divider, one quotient bit per cycle over
// the sum width (18 bits by default), and no new pixel is taken while the
// divider runs, and its result is registered when it is done. The output
// register holds one result; a new pixel is taken while it waits, but the
// next result cannot be placed until the receiver takes the previous beat.
// Reset clears the position counters and loads default registers; the
// line store is not cleared, since each entry is written at the top-left
// pixel of its block before it is read.
`include "box_filter_image_downscaler_macros.svh"
module box_filter_image_downscaler import bfd_pkg::*; #(
  parameter int MAX_WIDTH    = 512,
  parameter int MAX_SCALE    = 16,
  parameter int CHANNEL_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  blue,
  input  logic [7:0]  green,
  input  logic [7:0]  red,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  blue_out,
  output logic [7:0]  green_out,
  output logic [7:0]  red_out,
  output logic [8:0]  out_col,
  output logic [8:0]  out_row,
  output logic        frame_end
);
  localparam int SlotBits = $clog2(MAX_WIDTH);
  localparam int PhBits   = $clog2(MAX_SCALE);
  localparam int CntBits  = 2 * $clog2(MAX_SCALE + 1);
  localparam int SumBits  = CHANNEL_BITS + CntBits;

  // Configuration registers.
  logic [9:0] image_width, image_height;
  logic [4:0] scale_factor;
  logic       average_mode;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 10'd512;
      image_height <= 10'd512;
      scale_factor <= 5'd2;
      average_mode <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (reg_index_t'(paddr[3:2]))
        REG_WIDTH:  image_width  <= pwdata[9:0];
        REG_HEIGHT: image_height <= pwdata[9:0];
        REG_SCALE:  scale_factor <= pwdata[4:0];
        REG_MODE:   average_mode <= pwdata[0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (reg_index_t'(paddr[3:2]))
      REG_WIDTH:  prdata = {22'd0, image_width};
      REG_HEIGHT: prdata = {22'd0, image_height};
      REG_SCALE:  prdata = {27'd0, scale_factor};
      REG_MODE:   prdata = {31'd0, average_mode};
      default:    prdata = '0;
    endcase
  end

  // Saturated register values.
  logic [12:0] w_eff, h_eff;
  logic [6:0]  s_eff;
  always_comb begin
    w_eff = (image_width == '0) ? 13'd1 :
            (13'(image_width) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(image_width);
    h_eff = (image_height == '0) ? 13'd1 :
            (13'(image_height) > 13'(RowLimit)) ? 13'(RowLimit) : 13'(image_height);
    s_eff = (scale_factor == '0) ? 7'd1 :
            (7'(scale_factor) > 7'(MAX_SCALE)) ? 7'(MAX_SCALE) : 7'(scale_factor);
  end

  // Position state. The output slot is counted directly instead of dividing.
  logic [12:0] pixel_col, pixel_row;
  logic [PhBits:0] col_phase, row_phase;
  logic [12:0] slot, out_row_cnt;

  // Pixel pipeline: a read stage, then an update stage.
  logic busy, upd;
  logic [NumChannels-1:0][CHANNEL_BITS-1:0] pix;
  logic first_q, emit_q, fend_q;
  logic [12:0] slot_q, orow_q;
  logic [CntBits-1:0] cnt_q;
  logic [NumChannels*SumBits-1:0] rd_data, wr_data;
  logic [NumChannels-1:0][SumBits-1:0] acc;
  logic div_busy, div_start, div_done;
  logic [NumChannels-1:0][CHANNEL_BITS-1:0] quo;
  logic out_full;

  logic take;
  assign in_stall = busy | div_busy;
  assign take = in_valid & ~in_stall;

  logic row_end, last_row, blk_col, blk_row;
  always_comb begin
    row_end  = pixel_col >= w_eff - 13'd1;
    last_row = pixel_row >= h_eff - 13'd1;
    blk_col  = row_end || (7'(col_phase) >= s_eff - 7'd1);
    blk_row  = last_row || (7'(row_phase) >= s_eff - 7'd1);
  end

  bfd_ram #(.Width(NumChannels * SumBits), .Depth(MAX_WIDTH)) u_sums (
    .clk(clk), .wr_en(upd), .wr_addr(slot_q[SlotBits-1:0]), .wr_data(wr_data),
    .rd_addr(slot[SlotBits-1:0]), .rd_data(rd_data)
  );

  always_comb begin
    for (int c = 0; c < NumChannels; c++) begin
      logic [SumBits-1:0] old;
      old = rd_data[c*SumBits +: SumBits];
      if (first_q) acc[c] = SumBits'(pix[c]);
      else if (average_mode) acc[c] = old + SumBits'(pix[c]);
      else acc[c] = old;
      wr_data[c*SumBits +: SumBits] = acc[c];
    end
  end

  assign div_start = upd && emit_q && average_mode && !out_full;

  logic [NumChannels-1:0][SumBits-1:0] hold_acc;
  logic pend, pend_avg;
  bfd_divider #(.SumBits(SumBits), .CntBits(CntBits), .ChanBits(CHANNEL_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start | (pend & pend_avg & !out_full & !div_busy)),
    .dividend(pend ? hold_acc : acc), .divisor(cnt_q), .done(div_done), .quotient(quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_col <= '0; pixel_row <= '0; col_phase <= '0; row_phase <= '0;
      slot <= '0; out_row_cnt <= '0;
      busy <= 1'b0; upd <= 1'b0; div_busy <= 1'b0; out_full <= 1'b0; pend <= 1'b0;
    end else begin
      upd <= take;
      if (take) begin
        busy    <= 1'b1;
        pix     <= {CHANNEL_BITS'(red), CHANNEL_BITS'(green), CHANNEL_BITS'(blue)};
        first_q <= (row_phase == '0) && (col_phase == '0);
        emit_q  <= blk_col && blk_row;
        fend_q  <= row_end && last_row;
        slot_q  <= slot;
        orow_q  <= out_row_cnt;
        cnt_q   <= (CntBits'(row_phase) + CntBits'(1)) *
                   (CntBits'(col_phase) + CntBits'(1));
        if (row_end) begin
          pixel_col <= '0; col_phase <= '0; slot <= '0;
          if (last_row) begin
            pixel_row <= '0; row_phase <= '0; out_row_cnt <= '0;
          end else begin
            pixel_row <= pixel_row + 13'd1;
            if (blk_row) begin
              row_phase <= '0; out_row_cnt <= out_row_cnt + 13'd1;
            end else begin
              row_phase <= row_phase + 1'b1;
            end
          end
        end else begin
          pixel_col <= pixel_col + 13'd1;
          if (blk_col) begin
            col_phase <= '0;
            slot <= (slot == 13'(MAX_WIDTH - 1)) ? slot : slot + 13'd1;
          end else begin
            col_phase <= col_phase + 1'b1;
          end
        end
      end
      // Update stage: a block result either goes to output, divider, or waits; other pixels free the input.
      // A waiting result keeps busy high until it can move on.
      if (upd) begin
        if (emit_q) begin
          if (!out_full && !average_mode) begin
            out_full <= 1'b1; busy <= 1'b0;
            blue_out <= acc[0][7:0]; green_out <= acc[1][7:0]; red_out <= acc[2][7:0];
            out_col <= slot_q[8:0]; out_row <= orow_q[8:0]; frame_end <= fend_q;
          end else if (div_start) begin
            div_busy <= 1'b1; busy <= 1'b0;
          end else begin
            pend <= 1'b1; pend_avg <= average_mode; hold_acc <= acc;
          end
        end else begin
          busy <= 1'b0;
        end
      end
      if (out_valid && !out_stall) out_full <= 1'b0;
      if (pend && !out_full && !div_busy) begin
        if (pend_avg) begin
          div_busy <= 1'b1;
        end else begin
          out_full <= 1'b1;
          blue_out <= hold_acc[0][7:0]; green_out <= hold_acc[1][7:0];
          red_out <= hold_acc[2][7:0];
          out_col <= slot_q[8:0]; out_row <= orow_q[8:0]; frame_end <= fend_q;
        end
        pend <= 1'b0; busy <= 1'b0;
      end
      if (div_done) begin
        div_busy <= 1'b0; out_full <= 1'b1;
        blue_out <= quo[0][7:0]; green_out <= quo[1][7:0]; red_out <= quo[2][7:0];
        out_col <= slot_q[8:0]; out_row <= orow_q[8:0]; frame_end <= fend_q;
      end
    end
  end
  assign out_valid = out_full;

  `BFD_ASSERT_IMPL(a_no_take_busy, clk, rst, take, !busy && !div_busy, "pixel taken while busy")
  `BFD_ASSERT_IMPL(a_done_room, clk, rst, div_done, !out_full, "result overwrite")
  `BFD_ASSERT_NEXT(a_take_upd, clk, rst, take, upd, "update stage missed")
endmodule
